// ===== design/firq16_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package firq16_pkg;

	localparam int MAX_TAPS_DEF = 64;
	localparam int SAMPLE_W     = 16;
	localparam int ACC_W        = 32;
	localparam int OUT_SHIFT    = 16;
	localparam int TAP_CNT_W    = 7;
	localparam int TAP_IDX_W    = 6;

	localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RST = 7'd64;
	localparam logic [ACC_W-1:0]     ROUND_BIAS    = 32'h0000_8000;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_FILTER = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH1,
		ST_FLUSH2,
		ST_WB
	} fsm_state_t;

	typedef struct packed {
		logic shift;
		logic rotate;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/firq16_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module firq16_cell (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire firq16_pkg::cell_ctrl_t           ctrl,
	input  wire logic signed [firq16_pkg::SAMPLE_W-1:0] from_newer,
	input  wire logic signed [firq16_pkg::SAMPLE_W-1:0] from_older,
	output logic signed [firq16_pkg::SAMPLE_W-1:0]      sample
);

	logic signed [firq16_pkg::SAMPLE_W-1:0] sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (ctrl.shift) begin
			sample_q <= from_newer;
		end else if (ctrl.rotate) begin
			sample_q <= from_older;
		end
	end

	assign sample = sample_q;

endmodule

`default_nettype wire

// ===== design/firq16_coef_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module firq16_coef_mem #(
	parameter int DEPTH = firq16_pkg::MAX_TAPS_DEF,
	parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire                                          clk,
	input  wire                                          arst_n,
	input  wire                                          we,
	input  wire logic [IDX_W-1:0]                        waddr,
	input  wire logic signed [firq16_pkg::SAMPLE_W-1:0]  wdata,
	input  wire logic [IDX_W-1:0]                        raddr,
	output logic signed [firq16_pkg::SAMPLE_W-1:0]       rdata
);

	logic signed [firq16_pkg::SAMPLE_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]                       vld_q;
	logic signed [firq16_pkg::SAMPLE_W-1:0] rd_q;
	logic                                   rv_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	// unwritten slots read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rv_q  <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rv_q <= vld_q[raddr];
		end
	end

	assign rdata = rv_q ? rd_q : '0;

endmodule

`default_nettype wire

// ===== design/firq16_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none

module firq16_mac (
	input  wire                                          clk,
	input  wire                                          arst_n,
	input  wire                                          clear,
	input  wire                                          en,
	input  wire logic signed [firq16_pkg::SAMPLE_W-1:0]  sample,
	input  wire logic signed [firq16_pkg::SAMPLE_W-1:0]  coef,
	output logic [firq16_pkg::ACC_W-1:0]                 acc
);

	logic signed [firq16_pkg::ACC_W-1:0] prod_s2;
	logic                                en_s2;
	logic [firq16_pkg::ACC_W-1:0]        acc_q;

	always_ff @(posedge clk) begin
		prod_s2 <= firq16_pkg::ACC_W'(sample) * firq16_pkg::ACC_W'(coef);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s2 <= 1'b0;
			acc_q <= '0;
		end else begin
			en_s2 <= en;
			if (clear) begin
				acc_q <= '0;
			end else if (en_s2) begin
				acc_q <= acc_q + prod_s2;
			end
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

// ===== design/fir_filter_q16_round_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel | signals                               | request
// --------+---------------------------------------+----------------------
// in      | in_valid in_stall cmd tap_index value | load coef or sample
// out     | out_valid out_stall filtered          | one per sample
// cfg     | cfg_we cfg_data                       | tap_count write
//
// Load request: no stall follows. Sample request: in_stall stays high through
// RUN, FLUSH1, FLUSH2 and WB; the delay line rotates once around its cells
// while one shared multiply-accumulate steps through the taps. Output register
// holds a result under out_stall; the next request is still taken, its result
// waiting in WB. Reset clears delay line, coefficient valid bits and state.

module fir_filter_q16_round_core #(
	parameter int MAX_TAPS = firq16_pkg::MAX_TAPS_DEF
) (
	input  wire                                              clk,
	input  wire                                              arst_n,
	input  wire                                              in_valid,
	output logic                                             in_stall,
	input  wire logic                                        cmd,
	input  wire logic [firq16_pkg::TAP_IDX_W-1:0]            tap_index,
	input  wire logic signed [firq16_pkg::SAMPLE_W-1:0]      value,
	output logic                                             out_valid,
	input  wire                                              out_stall,
	output logic signed [firq16_pkg::SAMPLE_W-1:0]           filtered,
	input  wire                                              cfg_we,
	input  wire logic [firq16_pkg::TAP_CNT_W-1:0]            cfg_data
);

	localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int CNT_W = $clog2(MAX_TAPS + 1);
	localparam int EXT_W = (CNT_W > firq16_pkg::TAP_CNT_W) ? CNT_W : firq16_pkg::TAP_CNT_W;
	localparam logic [EXT_W-1:0] MAX_EXT  = EXT_W'(MAX_TAPS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TAPS - 1);

	firq16_pkg::fsm_state_t state_q, state_d;
	firq16_pkg::cell_ctrl_t cell_ctrl;

	logic [firq16_pkg::TAP_CNT_W-1:0]       tap_count_q;
	logic [IDX_W-1:0]                       step_q;
	logic signed [firq16_pkg::SAMPLE_W-1:0] dl [MAX_TAPS];
	logic signed [firq16_pkg::SAMPLE_W-1:0] head_s1;
	logic                                   en_s1;
	logic signed [firq16_pkg::SAMPLE_W-1:0] coef_rd;
	logic [firq16_pkg::ACC_W-1:0]           acc;
	logic [firq16_pkg::ACC_W-1:0]           rounded;
	logic signed [firq16_pkg::SAMPLE_W-1:0] out_q;
	logic                                   out_valid_q;

	logic             accept;
	logic             take_load;
	logic             take_sample;
	logic [EXT_W-1:0] cnt_ext;
	logic [EXT_W-1:0] taps;
	logic [EXT_W-1:0] step_ext;
	logic [EXT_W-1:0] rd_off;
	logic [EXT_W-1:0] idx_ext;
	logic             step_en;
	logic             last_step;
	logic             out_load;

	assign accept      = in_valid && !in_stall;
	assign take_load   = accept && (cmd == firq16_pkg::CMD_LOAD) && (idx_ext < MAX_EXT);
	assign take_sample = accept && (cmd == firq16_pkg::CMD_FILTER);

	assign cnt_ext  = EXT_W'(tap_count_q);
	assign taps     = (cnt_ext > MAX_EXT) ? MAX_EXT : cnt_ext;
	assign idx_ext  = EXT_W'(tap_index);
	assign step_ext = EXT_W'(step_q);
	assign step_en  = step_ext < taps;
	assign rd_off   = taps - EXT_W'(1) - step_ext;
	assign last_step = (step_q == LAST_IDX);

	assign cell_ctrl.shift  = take_sample;
	assign cell_ctrl.rotate = (state_q == firq16_pkg::ST_RUN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= firq16_pkg::TAP_COUNT_RST;
		end else if (cfg_we) begin
			tap_count_q <= cfg_data;
		end
	end

	// delay line: cell 0 newest; shift on sample, rotate toward cell 0 while running
	for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
		logic signed [firq16_pkg::SAMPLE_W-1:0] newer;
		logic signed [firq16_pkg::SAMPLE_W-1:0] older;
		if (k == 0) begin : g_first
			assign newer = value;
		end else begin : g_mid
			assign newer = dl[k-1];
		end
		if (k == MAX_TAPS - 1) begin : g_last
			assign older = dl[0];
		end else begin : g_inner
			assign older = dl[k+1];
		end
		firq16_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cell_ctrl),
			.from_newer (newer),
			.from_older (older),
			.sample     (dl[k])
		);
	end

	firq16_coef_mem #(
		.DEPTH (MAX_TAPS),
		.IDX_W (IDX_W)
	) u_coef (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (take_load),
		.waddr  (idx_ext[IDX_W-1:0]),
		.wdata  (value),
		.raddr  (rd_off[IDX_W-1:0]),
		.rdata  (coef_rd)
	);

	always_ff @(posedge clk) begin
		head_s1 <= dl[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
		end else begin
			en_s1 <= (state_q == firq16_pkg::ST_RUN) && step_en;
		end
	end

	firq16_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (take_sample),
		.en     (en_s1),
		.sample (head_s1),
		.coef   (coef_rd),
		.acc    (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (take_sample) begin
			step_q <= '0;
		end else if (state_q == firq16_pkg::ST_RUN) begin
			step_q <= step_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= firq16_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		out_load = 1'b0;
		unique case (state_q)
			firq16_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (take_sample) begin
					state_d = firq16_pkg::ST_RUN;
				end
			end
			firq16_pkg::ST_RUN: begin
				if (last_step) begin
					state_d = firq16_pkg::ST_FLUSH1;
				end
			end
			firq16_pkg::ST_FLUSH1: begin
				state_d = firq16_pkg::ST_FLUSH2;
			end
			firq16_pkg::ST_FLUSH2: begin
				state_d = firq16_pkg::ST_WB;
			end
			firq16_pkg::ST_WB: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = firq16_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = firq16_pkg::ST_IDLE;
			end
		endcase
	end

	assign rounded = acc + firq16_pkg::ROUND_BIAS;

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= rounded[firq16_pkg::OUT_SHIFT +: firq16_pkg::SAMPLE_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign filtered  = out_q;

endmodule

`default_nettype wire

// ===== verif/tb_fir_filter_q16_round_core.sv =====
`timescale 1ns / 1ps

module tb_fir_filter_q16_round_core;

	import firq16_pkg::*;

	localparam int MAX_TAPS = MAX_TAPS_DEF;
	localparam int PHASE_ITEMS = 230;

	typedef enum logic {ROW_REQ, ROW_TAPS} row_kind_t;

	// ROW_TAPS rows carry the new tap count in val
	typedef struct packed {
		row_kind_t kind;
		logic op;
		logic [TAP_IDX_W-1:0] idx;
		logic signed [SAMPLE_W-1:0] val;
		logic known;
		logic signed [SAMPLE_W-1:0] want;
	} plan_row_t;

	localparam int PLAN_N = 26;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic cmd;
	logic [TAP_IDX_W-1:0] tap_index;
	logic signed [SAMPLE_W-1:0] value;
	logic out_valid;
	logic out_stall;
	logic signed [SAMPLE_W-1:0] filtered;
	logic cfg_we;
	logic [TAP_CNT_W-1:0] cfg_data;

	logic signed [SAMPLE_W-1:0] hist [MAX_TAPS];
	logic signed [SAMPLE_W-1:0] coef_tbl [MAX_TAPS];
	logic [TAP_CNT_W-1:0] tap_cnt = TAP_COUNT_RST;
	logic signed [SAMPLE_W-1:0] pending_outputs [$];
	int fails = 0;

	plan_row_t plan [PLAN_N] = '{
		'{ROW_REQ,  CMD_FILTER, 6'd0,  16'sh1234,   1'b1, 16'sh0000},
		'{ROW_REQ,  CMD_FILTER, 6'd0,  -16'sd32768, 1'b1, 16'sh0000},
		'{ROW_REQ,  CMD_LOAD,   6'd63, -16'sd32768, 1'b0, 16'sh0000},
		'{ROW_REQ,  CMD_LOAD,   6'd0,  16'sd32767,  1'b0, 16'sh0000},
		'{ROW_REQ,  CMD_FILTER, 6'd0,  -16'sd32768, 1'b1, 16'sh4000},
		'{ROW_REQ,  CMD_FILTER, 6'd0,  16'sd32767,  1'b1, 16'shC001},
		'{ROW_REQ,  CMD_LOAD,   6'd62, -16'sd32768, 1'b0, 16'sh0000},
		'{ROW_REQ,  CMD_LOAD,   6'd61, -16'sd32768, 1'b0, 16'sh0000},
		'{ROW_REQ,  CMD_LOAD,   6'd60, -16'sd32768, 1'b0, 16'sh0000},
		'{ROW_REQ,  CMD_FILTER, 6'd0,  -16'sd32768, 1'b0, 16'sh0000},
		'{ROW_REQ,  CMD_FILTER, 6'd0,  -16'sd32768, 1'b0, 16'sh0000},
		'{ROW_REQ,  CMD_FILTER, 6'd0,  -16'sd32768, 1'b0, 16'sh0000},
		'{ROW_REQ,  CMD_FILTER, 6'd0,  -16'sd32768, 1'b0, 16'sh0000},
		'{ROW_TAPS, CMD_LOAD,   6'd0,  16'sd0,      1'b0, 16'sh0000},
		'{ROW_REQ,  CMD_FILTER, 6'd0,  16'sd32767,  1'b1, 16'sh0000},
		'{ROW_REQ,  CMD_FILTER, 6'd0,  -16'sd32768, 1'b1, 16'sh0000},
		'{ROW_TAPS, CMD_LOAD,   6'd0,  16'sd127,    1'b0, 16'sh0000},
		'{ROW_REQ,  CMD_FILTER, 6'd0,  16'sd12345,  1'b0, 16'sh0000},
		'{ROW_TAPS, CMD_LOAD,   6'd0,  16'sd1,      1'b0, 16'sh0000},
		'{ROW_REQ,  CMD_FILTER, 6'd0,  16'sd32767,  1'b1, 16'sh3FFF},
		'{ROW_REQ,  CMD_FILTER, 6'd0,  -16'sd1,     1'b1, 16'sh0000},
		'{ROW_REQ,  CMD_FILTER, 6'd0,  -16'sd32768, 1'b1, 16'shC001},
		'{ROW_REQ,  CMD_LOAD,   6'd0,  -16'sd32768, 1'b0, 16'sh0000},
		'{ROW_REQ,  CMD_FILTER, 6'd0,  -16'sd32768, 1'b1, 16'sh4000},
		'{ROW_TAPS, CMD_LOAD,   6'd0,  16'sd64,     1'b0, 16'sh0000},
		'{ROW_REQ,  CMD_FILTER, 6'd0,  16'sd0,      1'b0, 16'sh0000}
	};

	fir_filter_q16_round_core #(
		.MAX_TAPS(MAX_TAPS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.tap_index(tap_index),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.filtered(filtered),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#40ms;
		$display("tb_fir_filter_q16_round_core NOT OK");
		$finish;
	end

	function automatic logic signed [SAMPLE_W-1:0] fir_output();
		logic [ACC_W-1:0] acc;
		logic signed [ACC_W-1:0] prod;
		int n;
		n = (tap_cnt > MAX_TAPS) ? MAX_TAPS : tap_cnt;
		acc = '0;
		for (int j = 0; j < n; j++) begin
			prod = coef_tbl[j] * hist[n-1-j];
			acc = acc + prod;
		end
		acc = acc + ROUND_BIAS;
		return acc[ACC_W-1:OUT_SHIFT];
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0) begin
			case ($urandom_range(0, 3))
				0: return -16'sd32768;
				1: return 16'sd32767;
				2: return 16'sd0;
				default: return -16'sd1;
			endcase
		end
		if (r <= 3)
			return SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
		return SAMPLE_W'($urandom);
	endfunction

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_req(input logic op, input logic [TAP_IDX_W-1:0] idx,
			input logic signed [SAMPLE_W-1:0] v, input int gap, input logic known,
			input logic signed [SAMPLE_W-1:0] want);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		cmd <= op;
		tap_index <= idx;
		value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (op == CMD_LOAD) begin
			coef_tbl[idx] = v;
		end else begin
			for (int j = MAX_TAPS - 1; j > 0; j--)
				hist[j] = hist[j-1];
			hist[0] = v;
			pending_outputs.push_back(known ? want : fir_output());
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_outputs.size() != 0) @(posedge clk);
	endtask

	// loads give no result, so allow a full sample pass before touching the register
	task automatic set_tap_count(input logic [TAP_CNT_W-1:0] n);
		wait_drained();
		repeat (MAX_TAPS + 8) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= n;
		@(negedge clk);
		cfg_we <= 1'b0;
		tap_cnt = n;
	endtask

	initial begin
		int left;
		logic level;
		out_stall = 1'b0;
		left = 0;
		level = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (left == 0) begin
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5, 6, 7, 8: begin
						level = 1'b0;
						left = $urandom_range(1, 40);
					end
					9, 10, 11, 12, 13, 14, 15: begin
						level = 1'b1;
						left = $urandom_range(1, 3);
					end
					16, 17, 18: begin
						level = 1'b0;
						left = $urandom_range(1, 2);
					end
					default: begin
						level = 1'b1;
						left = $urandom_range(20, 80);
					end
				endcase
			end
			out_stall <= level;
			left--;
		end
	end

	always @(posedge clk) begin
		logic signed [SAMPLE_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_outputs.size() == 0) begin
				$error("filtered: no result expected, got %0d", filtered);
				fails++;
			end else begin
				want = pending_outputs.pop_front();
				if (filtered !== want) begin
					$error("filtered: expected %0d, got %0d", want, filtered);
					fails++;
				end
			end
		end
	end

	initial begin
		int eff;
		logic op;
		logic [TAP_IDX_W-1:0] idx;
		logic [TAP_CNT_W-1:0] n;
		in_valid = 1'b0;
		cmd = CMD_LOAD;
		tap_index = '0;
		value = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		for (int j = 0; j < MAX_TAPS; j++) begin
			hist[j] = '0;
			coef_tbl[j] = '0;
		end
		wait (arst_n === 1'b1);

		for (int k = 0; k < PLAN_N; k++) begin
			if (plan[k].kind == ROW_TAPS)
				set_tap_count(plan[k].val[TAP_CNT_W-1:0]);
			else
				send_req(plan[k].op, plan[k].idx, plan[k].val, $urandom_range(0, 2),
					plan[k].known, plan[k].want);
		end

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: n = 7'd64;
				1: n = 7'd1;
				2: n = TAP_CNT_W'($urandom_range(2, 63));
				3: n = 7'd0;
				4: n = TAP_CNT_W'($urandom_range(65, 126));
				5: n = 7'd127;
				6: n = 7'd63;
				default: n = TAP_CNT_W'($urandom_range(1, 64));
			endcase
			set_tap_count(n);
			eff = (n > MAX_TAPS) ? MAX_TAPS : n;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 199) == 0)
					wait_drained();
				op = ($urandom_range(0, 3) == 0) ? CMD_LOAD : CMD_FILTER;
				if (eff > 0 && $urandom_range(0, 1) == 0)
					idx = TAP_IDX_W'($urandom_range(0, eff - 1));
				else
					idx = TAP_IDX_W'($urandom_range(0, MAX_TAPS - 1));
				send_req(op, idx, rand_sample(), (phase % 2 == 1) ? 0 : rand_gap(),
					1'b0, '0);
			end
		end

		wait_drained();
		repeat (MAX_TAPS + 20) @(posedge clk);
		if (fails == 0)
			$display("tb_fir_filter_q16_round_core OK");
		else
			$display("tb_fir_filter_q16_round_core NOT OK");
		$finish;
	end

endmodule
